[hdl/srms_pkg.sv]
// Shared constants, codes and types of the sorted range membership search.
`timescale 1ns / 1ps

package srms_pkg;

    // Table geometry
    localparam int MAX_RANGES = 256;
    localparam int NUM_W      = 31;
    localparam int ENTRY_W    = 2 * NUM_W;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int MODE_W     = 2;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Result handed from the controller to the output register
    typedef struct packed {
        logic valid;
        logic hit;
        logic status;
    } res_t;

endpackage

[hdl/srms_if.sv]
// Request and response channel interfaces of the sorted range membership search.
`timescale 1ns / 1ps

interface srms_req_if
    import srms_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    num_t              range_first;
    num_t              range_last;
    num_t              query_chunk;

    modport source (output valid, mode, range_first, range_last, query_chunk, input ready);
    modport sink   (input valid, mode, range_first, range_last, query_chunk, output ready);
endinterface

interface srms_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic status;

    modport source (output valid, hit, status, input ready);
    modport sink   (input valid, hit, status, output ready);
endinterface

[hdl/srms_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module srms_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 62,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/srms_ctrl.sv]
// Controller: entry count, appends, clears and the binary search over the range RAM.
`timescale 1ns / 1ps

module srms_ctrl
    import srms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [MODE_W-1:0]  req_mode,
    input  num_t               req_first,
    input  num_t               req_last,
    input  num_t               req_chunk,
    input  logic               out_free,
    output res_t               res,
    output logic               wr_en,
    output addr_t              wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    output addr_t              rd_addr,
    input  logic [ENTRY_W-1:0] rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   mid_reg, mid_next;
    num_t   q_reg, q_next;
    logic   hit_reg, hit_next;

    logic               accept;
    num_t               probe_first;
    num_t               probe_last;
    logic               below;
    logic               match;
    cnt_t               lo_s;
    cnt_t               hi_s;
    logic [CNT_W:0]     sum_s;

    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    // Compare the probed entry and narrow the window
    assign probe_first = rd_data[ENTRY_W-1:NUM_W];
    assign probe_last  = rd_data[NUM_W-1:0];
    assign below       = probe_last < q_reg;
    assign match       = !below && (probe_first <= q_reg);
    assign lo_s        = below ? (mid_reg + cnt_t'(1)) : lo_reg;
    assign hi_s        = below ? hi_reg : mid_reg;
    assign sum_s       = {1'b0, lo_s} + {1'b0, hi_s};

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = {req_first, req_last};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        q_next     = q_reg;
        hit_next   = hit_reg;
        wr_en      = 1'b0;
        res        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res.valid = 1'b1;
                    case (req_mode)
                        MODE_APPEND:
                        begin
                            if (count_reg < cnt_t'(MAX_RANGES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + cnt_t'(1);
                            end
                            else
                            begin
                                res.status = 1'b1;
                            end
                        end
                        MODE_QUERY:
                        begin
                            q_next  = req_chunk;
                            lo_next = '0;
                            hi_next = count_reg;
                            // First probe at the middle of the whole table
                            mid_next = count_reg >> 1;
                            if (count_reg != '0)
                            begin
                                res.valid  = 1'b0;
                                state_next = S_SEARCH;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res.valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                lo_next  = lo_s;
                hi_next  = hi_s;
                mid_next = sum_s[CNT_W:1];
                if (match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (lo_s >= hi_s)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    res.hit    = hit_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Probe address follows the next midpoint
    assign rd_addr = mid_next[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

    // Search window and key need no reset
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        q_reg   <= q_next;
    end

endmodule

[hdl/sorted_range_membership_search.sv]
// Top level of the sorted range membership search: RAM, controller and response register.
//
//  channel | dir | fields                                        | transfer when
//  --------+-----+-----------------------------------------------+---------------------
//  req     | in  | mode, range_first, range_last, query_chunk    | req.valid && req.ready
//  rsp     | out | hit, status                                   | rsp.valid && rsp.ready
//
//  Append, clear and unused modes finish in the cycle of transfer; the result shows next cycle.
//  A query on a table of n entries makes p <= ceil(log2(n+1)) probes, one probe per cycle
//  through the single RAM read port.
//  One item is worked at a time; a request is taken only when rsp is empty or transfers in
//  the same cycle, so a result held back by the receiver stalls the input.
//  rst_n clears the entry count and the control state; the RAM contents are not cleared.
`timescale 1ns / 1ps

module sorted_range_membership_search
    import srms_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    srms_req_if.sink        req,
    srms_rsp_if.source      rsp
);

    logic               out_free;
    res_t               res;
    logic               wr_en;
    addr_t              wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    addr_t              rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               valid_reg;
    logic               hit_reg;
    logic               status_reg;

    // Response register is free when empty or being drained
    assign out_free = !valid_reg || rsp.ready;

    srms_ram #(
        .DEPTH (MAX_RANGES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_mode  (req.mode),
        .req_first (req.range_first),
        .req_last  (req.range_last),
        .req_chunk (req.query_chunk),
        .out_free  (out_free),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Hold the result until the response transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            hit_reg    <= res.hit;
            status_reg <= res.status;
        end
    end

    assign rsp.valid  = valid_reg;
    assign rsp.hit    = hit_reg;
    assign rsp.status = status_reg;

endmodule

[hdl/srms_checker.sv]
// Port-level assertions for the sorted range membership search, bound to the top level.
`timescale 1ns / 1ps

module srms_checker
    import srms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [MODE_W-1:0] req_mode,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_hit,
    input logic              rsp_status
);

    cnt_t count_reg;
    logic req_xfer;
    logic full;

    assign req_xfer = req_valid && req_ready;
    assign full     = count_reg == cnt_t'(MAX_RANGES);

    // Track the table fill from the transfers seen on the request side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req_xfer && (req_mode == MODE_CLEAR))
        begin
            count_reg <= '0;
        end
        else if (req_xfer && (req_mode == MODE_APPEND) && !full)
        begin
            count_reg <= count_reg + cnt_t'(1);
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_hit && rsp_status))
        else $error("hit and status both set");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_mode == MODE_APPEND)
        |=> rsp_valid && !rsp_hit && (rsp_status == $past(full)))
        else $error("append result wrong");

    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_mode == MODE_QUERY) && (count_reg == '0)
        |=> rsp_valid && !rsp_hit && !rsp_status)
        else $error("query on empty table must miss at once");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req_mode == MODE_QUERY) && (count_reg != '0) |=> !req_ready)
        else $error("request taken during a search");

endmodule

bind sorted_range_membership_search srms_checker u_srms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_mode   (req.mode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_hit    (rsp.hit),
    .rsp_status (rsp.status)
);
